### rtl/pstl_pkg.sv
`timescale 1ns / 1ps

package pstl_pkg;

  // Width of the id and priority fields on the ports and in the token.
  localparam int unsigned IdPortW = 16;
  localparam int unsigned PrioW   = 16;
  localparam int unsigned PosW    = 4;

  // Operation codes on the input channel.
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_code_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BADINDEX = 2'd3
  } status_t;

  // Kind of work a token performs as it walks the chain. Rejected inserts,
  // clears and unknown codes walk the chain untouched.
  typedef enum logic [2:0] {
    T_APPEND,
    T_INSERT,
    T_REMOVE,
    T_READ,
    T_CLEAR,
    T_FULL,
    T_NOP
  } tok_op_t;

  // Token handed from cell to cell. The carry fields hold the entry being
  // pushed down on an insert, or the entry picked up on a read.
  typedef struct packed {
    tok_op_t                   op;
    logic [IdPortW-1:0]        id;
    logic signed [PrioW-1:0]   pr;
    logic [PosW-1:0]           pos;
    logic                      flag;
    logic [IdPortW-1:0]        cid;
    logic signed [PrioW-1:0]   cpr;
  } token_t;

endpackage

### rtl/priority_sorted_task_list.sv
`timescale 1ns / 1ps

// Stable priority-sorted task list of up to DEPTH entries held in a chain of
// cells. Each accepted operation launches a token into the first cell; the
// token moves one cell per clock and does the insert shift, removal, or read
// as it goes, and its result is registered once it leaves the last cell. The
// block holds one operation at a time: a new item is taken only once the chain
// is free and the result register is empty or being drained in the same cycle.
// Entry contents are not cleared at reset; only the count is, and no clearing
// pass is needed.
module priority_sorted_task_list #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic [15:0]        task_id,
  input  logic signed [15:0] priority_req,
  input  logic [3:0]         position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [15:0]        found_id,
  output logic signed [15:0] found_priority,
  output logic [4:0]         entry_count
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdW  = (ID_BITS < 16) ? ID_BITS : 16;

  logic                 busy;
  logic [CntW-1:0]      count;
  logic [CntW-1:0]      cnt_new;
  logic                 in_xfer;
  logic                 full;
  logic                 done;
  logic [15:0]          id_masked;
  pstl_pkg::token_t     tok_launch;
  pstl_pkg::status_t    st_new;
  logic [15:0]          rid_new;
  logic signed [15:0]   rpr_new;

  logic                 tok_v [DEPTH+1];
  pstl_pkg::token_t     tok   [DEPTH+1];
  logic [IdW-1:0]       ent_id [DEPTH];
  logic signed [15:0]   ent_pr [DEPTH];

  assign in_ready  = !busy && (!out_valid || out_ready);
  assign in_xfer   = in_valid && in_ready;
  assign full      = count == CntW'(DEPTH);
  assign id_masked = 16'(task_id[IdW-1:0]);
  assign done      = tok_v[DEPTH];

  // Build the token for a new operation.
  always_comb begin
    tok_launch      = '0;
    tok_launch.id   = id_masked;
    tok_launch.pr   = priority_req;
    tok_launch.pos  = position;
    tok_launch.flag = 1'b0;
    case (operation)
      pstl_pkg::OP_APPEND, pstl_pkg::OP_INSERT: begin
        if (full) begin
          tok_launch.op = pstl_pkg::T_FULL;
        end else begin
          tok_launch.op  = (operation == pstl_pkg::OP_INSERT) ?
                           pstl_pkg::T_INSERT : pstl_pkg::T_APPEND;
          tok_launch.cid = id_masked;
          tok_launch.cpr = priority_req;
        end
      end
      pstl_pkg::OP_REMOVE: tok_launch.op = pstl_pkg::T_REMOVE;
      pstl_pkg::OP_READ:   tok_launch.op = pstl_pkg::T_READ;
      pstl_pkg::OP_CLEAR:  tok_launch.op = pstl_pkg::T_CLEAR;
      default:             tok_launch.op = pstl_pkg::T_NOP;
    endcase
  end

  assign tok_v[0] = in_xfer;
  assign tok[0]   = tok_launch;

  // The chain of entry cells.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [IdW-1:0]     nxt_id;
    logic signed [15:0] nxt_pr;

    if (k == DEPTH - 1) begin : g_last
      assign nxt_id = '0;
      assign nxt_pr = '0;
    end else begin : g_mid
      assign nxt_id = ent_id[k+1];
      assign nxt_pr = ent_pr[k+1];
    end

    pstl_cell #(
      .IDX   (k),
      .ID_W  (IdW),
      .CNT_W (CntW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .count         (count),
      .tok_in_valid  (tok_v[k]),
      .tok_in        (tok[k]),
      .nxt_id        (nxt_id),
      .nxt_pr        (nxt_pr),
      .ent_id        (ent_id[k]),
      .ent_pr        (ent_pr[k]),
      .tok_out_valid (tok_v[k+1]),
      .tok_out       (tok[k+1])
    );
  end

  // Result of the token leaving the last cell.
  always_comb begin
    st_new  = pstl_pkg::ST_OK;
    rid_new = '0;
    rpr_new = '0;
    cnt_new = count;
    case (tok[DEPTH].op)
      pstl_pkg::T_APPEND, pstl_pkg::T_INSERT: begin
        cnt_new = count + CntW'(1);
      end
      pstl_pkg::T_REMOVE: begin
        if (tok[DEPTH].flag) begin
          cnt_new = count - CntW'(1);
        end else begin
          st_new = pstl_pkg::ST_NOTFOUND;
        end
      end
      pstl_pkg::T_READ: begin
        if (tok[DEPTH].flag) begin
          rid_new = tok[DEPTH].cid;
          rpr_new = tok[DEPTH].cpr;
        end else begin
          st_new = pstl_pkg::ST_BADINDEX;
        end
      end
      pstl_pkg::T_CLEAR: cnt_new = '0;
      pstl_pkg::T_FULL:  st_new  = pstl_pkg::ST_FULL;
      default:           st_new  = pstl_pkg::ST_OK;
    endcase
  end

  // Control state: busy flag, count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        count     <= cnt_new;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (done) begin
      status         <= st_new;
      found_id       <= rid_new;
      found_priority <= rpr_new;
      entry_count    <= 5'(cnt_new);
    end
  end

endmodule

### rtl/pstl_cell.sv
`timescale 1ns / 1ps

module pstl_cell #(
  parameter int IDX   = 0,
  parameter int ID_W  = 16,
  parameter int CNT_W = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CNT_W-1:0]         count,
  input  logic                     tok_in_valid,
  input  pstl_pkg::token_t         tok_in,
  input  logic [ID_W-1:0]          nxt_id,
  input  logic signed [15:0]       nxt_pr,
  output logic [ID_W-1:0]          ent_id,
  output logic signed [15:0]       ent_pr,
  output logic                     tok_out_valid,
  output pstl_pkg::token_t         tok_out
);

  logic             occ;
  logic             at_or_below;
  logic             greater;
  logic             shift;
  logic             hit;
  logic             wr;
  logic [ID_W-1:0]  wr_id;
  logic signed [15:0] wr_pr;
  pstl_pkg::token_t tok_next;

  // This cell holds a live entry when its index is below the count.
  assign occ         = CNT_W'(IDX) < count;
  assign at_or_below = CNT_W'(IDX) <= count;
  assign greater     = ent_pr > tok_in.pr;

  // Act on the passing token: place, shift, remove or pick up.
  always_comb begin
    tok_next = tok_in;
    wr       = 1'b0;
    wr_id    = ent_id;
    wr_pr    = ent_pr;
    shift    = 1'b0;
    hit      = 1'b0;
    if (tok_in_valid) begin
      case (tok_in.op)
        pstl_pkg::T_APPEND, pstl_pkg::T_INSERT: begin
          shift = tok_in.flag || !occ || (tok_in.op == pstl_pkg::T_INSERT && greater);
          if (shift && at_or_below) begin
            wr            = 1'b1;
            wr_id         = tok_in.cid[ID_W-1:0];
            wr_pr         = tok_in.cpr;
            tok_next.cid  = 16'(ent_id);
            tok_next.cpr  = ent_pr;
            tok_next.flag = 1'b1;
          end
        end
        pstl_pkg::T_REMOVE: begin
          hit = tok_in.flag || (occ && ent_id == tok_in.id[ID_W-1:0]);
          if (hit && occ) begin
            wr            = 1'b1;
            wr_id         = nxt_id;
            wr_pr         = nxt_pr;
            tok_next.flag = 1'b1;
          end
        end
        pstl_pkg::T_READ: begin
          if (occ && 32'(tok_in.pos) == 32'(IDX)) begin
            tok_next.flag = 1'b1;
            tok_next.cid  = 16'(ent_id);
            tok_next.cpr  = ent_pr;
          end
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      ent_id <= wr_id;
      ent_pr <= wr_pr;
    end
  end

  // Token hand-off to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule

### rtl/pstl_checker.sv
`timescale 1ns / 1ps

module pstl_checker #(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic [15:0]        found_id,
  input logic signed [15:0] found_priority,
  input logic [4:0]         entry_count
);

  // A waiting result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_id)
      && $stable(found_priority) && $stable(entry_count))
    else $error("result changed while stalled");

  // Only one operation is in flight: no input is taken right after one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // Read fields are zero unless the status is ok.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != pstl_pkg::ST_OK |-> found_id == 16'd0 && found_priority == 16'sd0)
    else $error("read fields nonzero on failed operation");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 31) || (32'(entry_count) <= 32'(DEPTH)))
    else $error("entry count beyond capacity");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind priority_sorted_task_list pstl_checker #(.DEPTH(DEPTH)) u_pstl_checker (.*);

### tb/priority_sorted_task_list_test.sv
`timescale 1ns / 1ps

module priority_sorted_task_list_test;

  localparam int LIST_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_CYCLES = 40;

  // Operation codes that the block ignores.
  localparam logic [2:0] OP_UNDEF_A = 3'd5;
  localparam logic [2:0] OP_UNDEF_B = 3'd6;
  localparam logic [2:0] OP_UNDEF_C = 3'd7;

  typedef struct packed {
    pstl_pkg::status_t  st;
    logic [15:0]        rid;
    logic signed [15:0] rpr;
    logic [4:0]         cnt;
  } result_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [15:0]        id;
    logic signed [15:0] pr;
    logic [3:0]         pos;
    logic               typed;
    result_t            want;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         operation;
  logic [15:0]        task_id;
  logic signed [15:0] priority_req;
  logic [3:0]         position;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [15:0]        found_id;
  logic signed [15:0] found_priority;
  logic [4:0]         entry_count;

  // Expectation typed into a directed row, carried along with its payload.
  logic               drive_typed;
  result_t            drive_want;

  // Predicted list contents, updated on every input transfer.
  logic [15:0]        held_ids [LIST_DEPTH];
  logic signed [15:0] held_prios [LIST_DEPTH];
  int                 held_count = 0;

  result_t            pending_results [$];
  int                 fail_count = 0;
  int                 cycle_count = 0;
  bit                 idle_on;
  int                 stall_left;
  stim_row_t          directed_rows [24];

  priority_sorted_task_list #(
    .DEPTH  (LIST_DEPTH),
    .ID_BITS(16)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .task_id       (task_id),
    .priority_req  (priority_req),
    .position      (position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found_id      (found_id),
    .found_priority(found_priority),
    .entry_count   (entry_count)
  );

  // Free-running clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Apply one operation to the predicted list and return the result it gives.
  function automatic result_t apply_list_op(input logic [2:0] op, input logic [15:0] id,
                                            input logic signed [15:0] pr,
                                            input logic [3:0] pos);
    result_t r;
    int slot;
    int hit;
    r.st  = pstl_pkg::ST_OK;
    r.rid = '0;
    r.rpr = '0;
    case (op)
      pstl_pkg::OP_APPEND, pstl_pkg::OP_INSERT: begin
        if (held_count >= LIST_DEPTH) begin
          r.st = pstl_pkg::ST_FULL;
        end else begin
          slot = held_count;
          // A sorted insert goes ahead of the first strictly larger priority.
          if (op == pstl_pkg::OP_INSERT) begin
            for (int k = 0; k < held_count; k++) begin
              if (held_prios[k] > pr) begin
                slot = k;
                break;
              end
            end
          end
          for (int k = held_count; k > slot; k--) begin
            held_ids[k]   = held_ids[k-1];
            held_prios[k] = held_prios[k-1];
          end
          held_ids[slot]   = id;
          held_prios[slot] = pr;
          held_count++;
        end
      end
      pstl_pkg::OP_REMOVE: begin
        hit = -1;
        for (int k = 0; k < held_count; k++) begin
          if (held_ids[k] == id) begin
            hit = k;
            break;
          end
        end
        if (hit < 0) begin
          r.st = pstl_pkg::ST_NOTFOUND;
        end else begin
          for (int k = hit; k + 1 < held_count; k++) begin
            held_ids[k]   = held_ids[k+1];
            held_prios[k] = held_prios[k+1];
          end
          held_count--;
        end
      end
      pstl_pkg::OP_READ: begin
        if (int'(pos) < held_count) begin
          r.rid = held_ids[pos];
          r.rpr = held_prios[pos];
        end else begin
          r.st = pstl_pkg::ST_BADINDEX;
        end
      end
      pstl_pkg::OP_CLEAR: begin
        held_count = 0;
      end
      default: begin
      end
    endcase
    r.cnt = held_count[4:0];
    return r;
  endfunction

  // Predict on input transfers and check each output transfer in order.
  always @(posedge clk) begin : track_results
    result_t predicted;
    result_t want;
    result_t got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predicted = apply_list_op(operation, task_id, priority_req, position);
        pending_results.push_back(drive_typed ? drive_want : predicted);
      end
      if (out_valid && out_ready) begin
        got.st  = pstl_pkg::status_t'(status);
        got.rid = found_id;
        got.rpr = found_priority;
        got.cnt = entry_count;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result st=%0d id=%h pr=%0d cnt=%0d", $time, status,
                   found_id, found_priority, entry_count);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected st=%0d id=%h pr=%0d cnt=%0d", $time, want.st,
                     want.rid, want.rpr, want.cnt);
            $display("%0t:          actual   st=%0d id=%h pr=%0d cnt=%0d", $time, got.st,
                     got.rid, got.rpr, got.cnt);
            fail_count++;
          end
        end
      end
    end
  end

  // Result side: ready drops in random bursts while idling is enabled.
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Present one item at the falling edge and hold it until its transfer.
  task automatic send_item(input logic [2:0] op, input logic [15:0] id,
                           input logic signed [15:0] pr, input logic [3:0] pos,
                           input logic typed, input result_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    operation    = op;
    task_id      = id;
    priority_req = pr;
    position     = pos;
    drive_typed  = typed;
    drive_want   = want;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Hold the input side until every outstanding result has come back.
  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [2:0]         op;
    logic [15:0]        id;
    logic signed [15:0] pr;
    logic [3:0]         pos;
    int                 roll;
    int                 fill_goal;
    rst          = 1'b1;
    in_valid     = 1'b0;
    operation    = pstl_pkg::OP_APPEND;
    task_id      = '0;
    priority_req = '0;
    position     = '0;
    drive_typed  = 1'b0;
    drive_want   = '0;
    idle_on      = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty-list errors, extremes, ties, reserved codes, clear.
    directed_rows = '{
      '{pstl_pkg::OP_READ,   16'h0000, 16'sh0000, 4'd0,  1'b1,
        '{pstl_pkg::ST_BADINDEX, 16'h0, 16'sh0, 5'd0}},
      '{pstl_pkg::OP_REMOVE, 16'h0005, 16'sh0000, 4'd0,  1'b1,
        '{pstl_pkg::ST_NOTFOUND, 16'h0, 16'sh0, 5'd0}},
      '{pstl_pkg::OP_APPEND, 16'hFFFF, 16'sh7FFF, 4'd15, 1'b1,
        '{pstl_pkg::ST_OK, 16'h0, 16'sh0, 5'd1}},
      '{pstl_pkg::OP_APPEND, 16'h0000, 16'sh8000, 4'd0,  1'b1,
        '{pstl_pkg::ST_OK, 16'h0, 16'sh0, 5'd2}},
      '{pstl_pkg::OP_INSERT, 16'h1234, 16'sh0000, 4'd0,  1'b0, '0},
      '{pstl_pkg::OP_INSERT, 16'h2222, 16'sh0000, 4'd0,  1'b0, '0},
      '{pstl_pkg::OP_INSERT, 16'h3333, 16'sh8000, 4'd0,  1'b0, '0},
      '{pstl_pkg::OP_READ,   16'h0000, 16'sh0000, 4'd0,  1'b0, '0},
      '{pstl_pkg::OP_READ,   16'h0000, 16'sh0000, 4'd1,  1'b0, '0},
      '{pstl_pkg::OP_READ,   16'h0000, 16'sh0000, 4'd2,  1'b0, '0},
      '{pstl_pkg::OP_READ,   16'h0000, 16'sh0000, 4'd3,  1'b0, '0},
      '{pstl_pkg::OP_READ,   16'h0000, 16'sh0000, 4'd4,  1'b0, '0},
      '{pstl_pkg::OP_READ,   16'h0000, 16'sh0000, 4'd15, 1'b1,
        '{pstl_pkg::ST_BADINDEX, 16'h0, 16'sh0, 5'd5}},
      '{pstl_pkg::OP_READ,   16'h0000, 16'sh0000, 4'd5,  1'b1,
        '{pstl_pkg::ST_BADINDEX, 16'h0, 16'sh0, 5'd5}},
      '{pstl_pkg::OP_REMOVE, 16'h1234, 16'sh0000, 4'd0,  1'b0, '0},
      '{pstl_pkg::OP_REMOVE, 16'h9999, 16'sh0000, 4'd0,  1'b1,
        '{pstl_pkg::ST_NOTFOUND, 16'h0, 16'sh0, 5'd4}},
      '{OP_UNDEF_A,          16'hFFFF, 16'sh7FFF, 4'd15, 1'b1,
        '{pstl_pkg::ST_OK, 16'h0, 16'sh0, 5'd4}},
      '{OP_UNDEF_B,          16'h0000, 16'sh8000, 4'd0,  1'b1,
        '{pstl_pkg::ST_OK, 16'h0, 16'sh0, 5'd4}},
      '{OP_UNDEF_C,          16'hA5A5, 16'sh5A5A, 4'd9,  1'b1,
        '{pstl_pkg::ST_OK, 16'h0, 16'sh0, 5'd4}},
      '{pstl_pkg::OP_CLEAR,  16'h0000, 16'sh0000, 4'd0,  1'b1,
        '{pstl_pkg::ST_OK, 16'h0, 16'sh0, 5'd0}},
      '{pstl_pkg::OP_READ,   16'h0000, 16'sh0000, 4'd0,  1'b1,
        '{pstl_pkg::ST_BADINDEX, 16'h0, 16'sh0, 5'd0}},
      '{pstl_pkg::OP_APPEND, 16'hABCD, 16'shFFFF, 4'd0,  1'b1,
        '{pstl_pkg::ST_OK, 16'h0, 16'sh0, 5'd1}},
      '{pstl_pkg::OP_READ,   16'h0000, 16'sh0000, 4'd0,  1'b1,
        '{pstl_pkg::ST_OK, 16'hABCD, 16'shFFFF, 5'd1}},
      '{pstl_pkg::OP_CLEAR,  16'h0000, 16'sh0000, 4'd0,  1'b1,
        '{pstl_pkg::ST_OK, 16'h0, 16'sh0, 5'd0}}
    };
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].id, directed_rows[i].pr,
                directed_rows[i].pos, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part. Each episode steers the list toward a fill level, so the
    // list is often filled to the brim and drained again.
    fill_goal = LIST_DEPTH;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 400 == 0) drain_results();
      idle_on = (n < RANDOM_ITEMS - 200) && ((n / 150) % 3 != 2);
      if (n > 0 && n % 60 == 0) begin
        fill_goal = ($urandom_range(0, 9) < 3) ? LIST_DEPTH
                                               : int'($urandom_range(0, LIST_DEPTH));
      end

      // Priorities: many ties near zero, full-range values and the extremes.
      roll = int'($urandom_range(0, 9));
      if (roll < 4) begin
        pr = $signed(16'($urandom_range(0, 4))) - 16'sd2;
      end else if (roll < 8) begin
        pr = 16'($urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: pr = 16'sh8000;
          1: pr = 16'sh7FFF;
          2: pr = 16'shFFFF;
          default: pr = 16'sh0000;
        endcase
      end
      // Ids: a small pool gives duplicates, the rest is full range.
      id  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
      pos = 4'($urandom);

      roll = int'($urandom_range(0, 99));
      if (roll < 2) begin
        op = 3'($urandom_range(OP_UNDEF_A, OP_UNDEF_C));
      end else if (roll < 4) begin
        op = pstl_pkg::OP_CLEAR;
      end else if (roll < 24) begin
        op = pstl_pkg::OP_READ;
        if (held_count > 0 && $urandom_range(0, 4) != 0) begin
          pos = 4'($urandom_range(0, held_count - 1));
        end
      end else if (held_count < fill_goal || $urandom_range(0, 9) == 0) begin
        op = ($urandom_range(0, 9) < 7) ? pstl_pkg::OP_INSERT : pstl_pkg::OP_APPEND;
      end else begin
        op = pstl_pkg::OP_REMOVE;
        if (held_count > 0 && $urandom_range(0, 9) < 7) begin
          id = held_ids[$urandom_range(0, held_count - 1)];
        end
      end
      send_item(op, id, pr, pos, 1'b0, '0);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
